>>> sv/psit_pkg.sv
// ----------------------------------------------------------------------------
// psit_pkg
// Shared widths, constants and types for the point set inertia tensor block.
// ----------------------------------------------------------------------------
package psit_pkg;
	localparam int MaxPoints  = 4096;
	localparam int CoordBits  = 20;
	localparam int AddrBits   = $clog2(MaxPoints);
	localparam int CountBits  = 13;
	localparam int SumBits    = 33;
	localparam int DiffBits   = CoordBits + 1;
	localparam int ProdBits   = 2 * DiffBits;
	localparam int AccBits    = 64;
	localparam int OutBits    = 63;
	localparam int EntryBits  = 3 * CoordBits;
	localparam int DivBits    = SumBits + 1;

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic signed [DiffBits-1:0]  diff_t;
	typedef logic signed [ProdBits-1:0]  prod_t;
	typedef logic        [AccBits-1:0]   acc_t;
	typedef logic        [CountBits-1:0] count_t;
	typedef logic signed [SumBits-1:0]   sum_t;

	typedef enum logic [6:0] {
		ST_LOAD  = 7'b0000001,
		ST_DIV   = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_DRAIN = 7'b0001000,
		ST_DONE  = 7'b0010000,
		ST_OUT   = 7'b0100000,
		ST_DIVST = 7'b1000000
	} state_t;
endpackage

>>> sv/psit_ram.sv
// ----------------------------------------------------------------------------
// psit_ram
// Generic single-port-write, single-port-read ram with registered read data.
// ----------------------------------------------------------------------------
module psit_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

>>> sv/psit_rdiv.sv
// ----------------------------------------------------------------------------
// psit_rdiv
// Bit-serial rounded divider: (2|s|+n) / 2n with the sign of s, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psit_rdiv (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  psit_pkg::sum_t        sum,
	input  psit_pkg::count_t      n,
	output logic                  busy,
	output psit_pkg::coord_t      quot
);
	localparam int DW = psit_pkg::DivBits + 1;
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] num_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] mag;
	logic [DW-1:0] rem_sh;

	always_comb begin
		if (sum[psit_pkg::SumBits-1]) begin
			mag = DW'(-{{(DW-psit_pkg::SumBits){sum[psit_pkg::SumBits-1]}}, sum});
		end else begin
			mag = DW'(sum);
		end
		rem_sh = {rem_q[DW-2:0], num_q[DW-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(DW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= DW'({mag[DW-2:0], 1'b0} + DW'(n));
			den_q <= DW'({n, 1'b0});
			rem_q <= '0;
			neg_q <= sum[psit_pkg::SumBits-1];
		end else if (cnt_q != '0) begin
			if (rem_sh >= den_q) begin
				rem_q <= rem_sh - den_q;
				num_q <= {num_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				num_q <= {num_q[DW-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = neg_q ? psit_pkg::CoordBits'(-num_q) : psit_pkg::CoordBits'(num_q);
endmodule

>>> sv/point_set_inertia_tensor_top.sv
// ----------------------------------------------------------------------------
// point_set_inertia_tensor_top
// Inertia tensor of a set of unit-mass points, accumulated from a point ram.
// ----------------------------------------------------------------------------
// Points are taken one per cycle while a set loads; counted ones go into a
// 4096-entry ram until it is full. The request carrying last_point starts
// the result: three serial dividers form the centre, then the ram is reread
// one point per cycle through a three-stage multiply and accumulate pipe;
// an empty set goes straight to its result. No input is taken while a result
// is computed or waits to be taken. No clearing pass is needed.
module point_set_inertia_tensor_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [psit_pkg::CoordBits-1:0] pos_x,
	input  logic [psit_pkg::CoordBits-1:0] pos_y,
	input  logic [psit_pkg::CoordBits-1:0] pos_z,
	input  logic                           counted,
	input  logic                           last_point,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [62:0]                    ixx,
	output logic [62:0]                    iyy,
	output logic [62:0]                    izz,
	output logic [62:0]                    ixy,
	output logic [62:0]                    ixz,
	output logic [62:0]                    iyz,
	output logic [psit_pkg::CoordBits-1:0] centre_x,
	output logic [psit_pkg::CoordBits-1:0] centre_y,
	output logic [psit_pkg::CoordBits-1:0] centre_z,
	output logic [12:0]                    point_count,
	output logic                           empty_set,
	output logic                           capacity_overflow
);
	localparam int CB = psit_pkg::CoordBits;
	localparam int AB = psit_pkg::AddrBits;

	psit_pkg::state_t state_q;
	psit_pkg::sum_t   sx_q, sy_q, sz_q;
	psit_pkg::count_t cnt_q;
	logic             ovf_q;
	psit_pkg::count_t rd_idx_q;
	psit_pkg::coord_t cx_q, cy_q, cz_q;
	psit_pkg::acc_t   acc_q [6];
	logic             v_s1, v_s2, v_s3;
	psit_pkg::diff_t  dx_s2, dy_s2, dz_s2;
	psit_pkg::prod_t  p_s3 [6];

	logic             accept;
	logic             store;
	logic             full;
	logic [psit_pkg::EntryBits-1:0] rd_data;
	logic [AB-1:0]    rd_addr;
	logic             busy_x, busy_y, busy_z;
	psit_pkg::coord_t qx, qy, qz;
	logic             div_start;

	assign in_stall  = (state_q != psit_pkg::ST_LOAD);
	assign accept    = in_valid && !in_stall;
	assign full      = (cnt_q == psit_pkg::CountBits'(psit_pkg::MaxPoints));
	assign store     = accept && counted && !full;
	assign rd_addr   = rd_idx_q[AB-1:0];
	assign div_start = (state_q == psit_pkg::ST_DIVST);

	psit_ram #(.Width(psit_pkg::EntryBits), .Depth(psit_pkg::MaxPoints)) u_store (
		.clk     (clk),
		.wr_en   (store),
		.wr_addr (cnt_q[AB-1:0]),
		.wr_data ({pos_z, pos_y, pos_x}),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	psit_rdiv u_div_x (.clk(clk), .arst_n(arst_n), .start(div_start), .sum(sx_q),
		.n(cnt_q), .busy(busy_x), .quot(qx));
	psit_rdiv u_div_y (.clk(clk), .arst_n(arst_n), .start(div_start), .sum(sy_q),
		.n(cnt_q), .busy(busy_y), .quot(qy));
	psit_rdiv u_div_z (.clk(clk), .arst_n(arst_n), .start(div_start), .sum(sz_q),
		.n(cnt_q), .busy(busy_z), .quot(qz));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= psit_pkg::ST_LOAD;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			sx_q     <= '0;
			sy_q     <= '0;
			sz_q     <= '0;
			rd_idx_q <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
		end else begin
			v_s1 <= (state_q == psit_pkg::ST_READ);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			unique case (state_q)
				psit_pkg::ST_LOAD: begin
					if (store) begin
						cnt_q <= cnt_q + 1'b1;
						sx_q  <= sx_q + psit_pkg::SumBits'(signed'(pos_x));
						sy_q  <= sy_q + psit_pkg::SumBits'(signed'(pos_y));
						sz_q  <= sz_q + psit_pkg::SumBits'(signed'(pos_z));
					end
					if (accept && counted && full) begin
						ovf_q <= 1'b1;
					end
					if (accept && last_point) begin
						if (cnt_q == '0 && !(store)) begin
							state_q <= psit_pkg::ST_OUT;
						end else begin
							state_q <= psit_pkg::ST_DIVST;
						end
					end
				end
				psit_pkg::ST_DIVST: begin
					state_q <= psit_pkg::ST_DIV;
				end
				psit_pkg::ST_DIV: begin
					if (!busy_x && !busy_y && !busy_z) begin
						rd_idx_q <= '0;
						state_q  <= psit_pkg::ST_READ;
					end
				end
				psit_pkg::ST_READ: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if (rd_idx_q == cnt_q - 1'b1) begin
						state_q <= psit_pkg::ST_DRAIN;
					end
				end
				psit_pkg::ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= psit_pkg::ST_DONE;
					end
				end
				psit_pkg::ST_DONE: begin
					state_q <= psit_pkg::ST_OUT;
				end
				psit_pkg::ST_OUT: begin
					if (!out_stall) begin
						state_q <= psit_pkg::ST_LOAD;
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						sx_q    <= '0;
						sy_q    <= '0;
						sz_q    <= '0;
					end
				end
				default: state_q <= psit_pkg::ST_LOAD;
			endcase
		end
	end

	// centre capture, offsets, products, accumulation
	always_ff @(posedge clk) begin
		if (state_q == psit_pkg::ST_DIV && !busy_x && !busy_y && !busy_z) begin
			cx_q <= qx;
			cy_q <= qy;
			cz_q <= qz;
			for (int k = 0; k < 6; k++) begin
				acc_q[k] <= '0;
			end
		end
		if (state_q == psit_pkg::ST_LOAD) begin
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
			for (int k = 0; k < 6; k++) begin
				acc_q[k] <= '0;
			end
		end
		dx_s2 <= psit_pkg::DiffBits'(signed'(rd_data[CB-1:0])) - psit_pkg::DiffBits'(cx_q);
		dy_s2 <= psit_pkg::DiffBits'(signed'(rd_data[2*CB-1:CB])) - psit_pkg::DiffBits'(cy_q);
		dz_s2 <= psit_pkg::DiffBits'(signed'(rd_data[3*CB-1:2*CB])) - psit_pkg::DiffBits'(cz_q);
		p_s3[0] <= dx_s2 * dx_s2;
		p_s3[1] <= dy_s2 * dy_s2;
		p_s3[2] <= dz_s2 * dz_s2;
		p_s3[3] <= dx_s2 * dy_s2;
		p_s3[4] <= dx_s2 * dz_s2;
		p_s3[5] <= dy_s2 * dz_s2;
		if (v_s3) begin
			acc_q[0] <= acc_q[0] + psit_pkg::AccBits'(p_s3[1]) + psit_pkg::AccBits'(p_s3[2]);
			acc_q[1] <= acc_q[1] + psit_pkg::AccBits'(p_s3[0]) + psit_pkg::AccBits'(p_s3[2]);
			acc_q[2] <= acc_q[2] + psit_pkg::AccBits'(p_s3[0]) + psit_pkg::AccBits'(p_s3[1]);
			acc_q[3] <= acc_q[3] - psit_pkg::AccBits'(p_s3[3]);
			acc_q[4] <= acc_q[4] - psit_pkg::AccBits'(p_s3[4]);
			acc_q[5] <= acc_q[5] - psit_pkg::AccBits'(p_s3[5]);
		end
	end

	assign out_valid         = (state_q == psit_pkg::ST_OUT);
	assign ixx               = acc_q[0][62:0];
	assign iyy               = acc_q[1][62:0];
	assign izz               = acc_q[2][62:0];
	assign ixy               = acc_q[3][62:0];
	assign ixz               = acc_q[4][62:0];
	assign iyz               = acc_q[5][62:0];
	assign centre_x          = cx_q;
	assign centre_y          = cy_q;
	assign centre_z          = cz_q;
	assign point_count       = cnt_q;
	assign empty_set         = (cnt_q == '0);
	assign capacity_overflow = ovf_q && (cnt_q != '0);
endmodule

>>> sv/psit_checker.sv
// ----------------------------------------------------------------------------
// psit_checker
// Port-level checks on the point set inertia tensor block.
// ----------------------------------------------------------------------------
module psit_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [62:0] ixx,
	input logic [12:0] point_count,
	input logic        empty_set,
	input logic        capacity_overflow
);
	// no input taken while a result is shown
	a_no_in_with_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while result pending");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (empty_set == (point_count == 13'd0))) else $error("empty flag mismatch");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && empty_set) |-> (ixx == '0 && !capacity_overflow))
		else $error("empty set result not zero");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(ixx)))
		else $error("stalled result changed");
endmodule

bind point_set_inertia_tensor_top psit_checker u_psit_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_stall          (in_stall),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.ixx               (ixx),
	.point_count       (point_count),
	.empty_set         (empty_set),
	.capacity_overflow (capacity_overflow)
);
